FILE: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

FILE: rtl/gao_pkg.sv
// Shared types and constants for the orbit block.
package gao_pkg;
	localparam int MAX_VERTICES = 8;
	localparam int VIDX_W = 3;
	localparam int ROW_W = 8;
	localparam int LABEL_W = 4;
	localparam int CNT_W = 4;

	typedef struct packed {
		logic [VIDX_W-1:0] row_index;
		logic [ROW_W-1:0] row_bits;
		logic last_row;
	} in_item_t;

	typedef struct packed {
		logic [VIDX_W-1:0] vertex;
		logic [LABEL_W-1:0] orbit_label;
		logic last;
	} out_item_t;

	// Control from the sequencer to the permutation unit.
	typedef struct packed {
		logic init;
		logic step;
	} perm_ctl_t;
endpackage

FILE: rtl/gao_if.sv
// Valid/ready channel interfaces.
interface gao_in_if;
	logic valid;
	logic ready;
	gao_pkg::in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface gao_out_if;
	logic valid;
	logic ready;
	gao_pkg::out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface gao_cfg_if;
	logic valid;
	logic ready;
	logic [gao_pkg::CNT_W-1:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: rtl/gao_perm.sv
// Permutation generator: one lexicographic successor step per cycle while ctl.step is set and a successor exists.
module gao_perm #(
	parameter int NV = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  gao_pkg::perm_ctl_t ctl,
	input  logic [gao_pkg::CNT_W-1:0] n,
	output logic [NV-1:0][gao_pkg::VIDX_W-1:0] perm,
	output logic done
);
	logic [NV-1:0][gao_pkg::VIDX_W-1:0] perm_q, nxt;
	logic [gao_pkg::CNT_W-1:0] piv, sw;
	logic found;

	assign perm = perm_q;

	// Successor: pivot search, swap, and suffix reversal, all combinational.
	always_comb begin
		nxt = perm_q;
		piv = '0;
		found = 1'b0;
		sw = '0;
		for (int i = 1; i < NV; i++) begin
			if (i < n && perm_q[i-1] < perm_q[i]) begin
				piv = gao_pkg::CNT_W'(i - 1);
				found = 1'b1;
			end
		end
		for (int j = 0; j < NV; j++) begin
			if (found && j < n && j > piv && perm_q[j] > perm_q[piv[gao_pkg::VIDX_W-1:0]])
				sw = gao_pkg::CNT_W'(j);
		end
		nxt[piv[gao_pkg::VIDX_W-1:0]] = perm_q[sw[gao_pkg::VIDX_W-1:0]];
		nxt[sw[gao_pkg::VIDX_W-1:0]] = perm_q[piv[gao_pkg::VIDX_W-1:0]];
		for (int j = 0; j < NV; j++) begin
			if (j > piv && j < n)
				nxt[j] = (n - 1 + piv + 1 - j == sw) ? perm_q[piv[gao_pkg::VIDX_W-1:0]]
					: perm_q[gao_pkg::VIDX_W'(n - 1 + piv + 1 - j)];
		end
		done = !found;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NV; i++) perm_q[i] <= gao_pkg::VIDX_W'(i);
		end else if (ctl.init) begin
			for (int i = 0; i < NV; i++) perm_q[i] <= gao_pkg::VIDX_W'(i);
		end else if (ctl.step && found) begin
			perm_q <= nxt;
		end
	end
endmodule

FILE: rtl/graph_automorphism_orbits_core.sv
// Top level: brute-force automorphism orbit labeling.
// Row items without last_row are taken whenever the block is in its load state.
// A last row starts a run: n! permutation checks at one per cycle
// (up to 40320 for eight vertices), then n results one per accepted cycle.
// The input is not ready during a run or while results drain.
// arst_n clears control state and sets the vertex count vc_q to 8.
`include "assert_macros.svh"
module graph_automorphism_orbits_core (
	input logic clk,
	input logic arst_n,
	gao_in_if.sink in_ch,
	gao_out_if.source out_ch,
	gao_cfg_if.sink cfg
);
	localparam logic [1:0] ST_LOAD = 2'd0;
	localparam logic [1:0] ST_RUN = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;
	localparam int NV = gao_pkg::MAX_VERTICES;

	logic [1:0] state_q;
	logic [gao_pkg::CNT_W-1:0] vc_q, n_q;
	logic [NV-1:0][gao_pkg::ROW_W-1:0] rows_q;
	logic [NV-1:0][NV-1:0] img_q;
	logic [gao_pkg::VIDX_W-1:0] k_q;
	logic [NV-1:0][gao_pkg::VIDX_W-1:0] perm;
	logic pdone, is_auto;
	gao_pkg::perm_ctl_t pctl;
	logic [gao_pkg::CNT_W-1:0] n_eff, label;

	assign cfg.ready = 1'b1;
	assign in_ch.ready = (state_q == ST_LOAD);
	assign n_eff = (vc_q == '0) ? gao_pkg::CNT_W'(1)
		: (vc_q > gao_pkg::CNT_W'(gao_pkg::MAX_VERTICES))
			? gao_pkg::CNT_W'(gao_pkg::MAX_VERTICES) : vc_q;

	assign pctl.init = in_ch.valid && in_ch.ready;
	assign pctl.step = (state_q == ST_RUN);

	gao_perm #(.NV(NV)) u_perm (
		.clk(clk), .arst_n(arst_n), .ctl(pctl), .n(n_q), .perm(perm), .done(pdone)
	);

	// Edge-preservation check of the current permutation.
	always_comb begin
		is_auto = 1'b1;
		for (int i = 0; i < NV; i++)
			for (int k = 0; k < NV; k++)
				if (i < n_q && k < n_q && rows_q[i][k] != rows_q[perm[i]][perm[k]])
					is_auto = 1'b0;
	end

	// Orbit label of the vertex being emitted.
	always_comb begin
		label = gao_pkg::CNT_W'(k_q) + 1'b1;
		for (int i = NV - 1; i >= 0; i--)
			if (i < n_q && img_q[i][k_q]) label = gao_pkg::CNT_W'(i + 1);
	end

	assign out_ch.valid = (state_q == ST_EMIT);
	assign out_ch.data.vertex = k_q;
	assign out_ch.data.orbit_label = label;
	assign out_ch.data.last = (gao_pkg::CNT_W'(k_q) + 1'b1 == n_q);

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) rows_q[in_ch.data.row_index] <= in_ch.data.row_bits;
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			vc_q <= gao_pkg::CNT_W'(8);
			n_q <= '0;
			k_q <= '0;
			img_q <= '0;
		end else begin
			if (cfg.valid && cfg.ready) vc_q <= cfg.data;
			unique case (state_q)
				ST_LOAD: begin
					if (in_ch.valid && in_ch.data.last_row) begin
						state_q <= ST_RUN;
						n_q <= n_eff;
						img_q <= '0;
						k_q <= '0;
					end
				end
				ST_RUN: begin
					if (is_auto)
						for (int i = 0; i < NV; i++)
							if (i < n_q) img_q[i][perm[i]] <= 1'b1;
					if (pdone) state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_ch.ready) begin
						k_q <= k_q + 1'b1;
						if (out_ch.data.last) state_q <= ST_LOAD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	`ASSERT_IMPL(a_no_in_busy, clk, arst_n, state_q != ST_LOAD, !in_ch.ready)
	`ASSERT_IMPL(a_label_le, clk, arst_n, out_ch.valid, out_ch.data.orbit_label <= gao_pkg::CNT_W'(out_ch.data.vertex) + 1'b1)
	`ASSERT_NEXT(a_last_ends, clk, arst_n, out_ch.valid && out_ch.ready && out_ch.data.last, state_q == ST_LOAD)
endmodule

FILE: sim/graph_automorphism_orbits_core_test.sv
// Self-checking testbench for the automorphism orbit labeling block.
module graph_automorphism_orbits_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NV = gao_pkg::MAX_VERTICES;
	localparam int WATCHDOG_LIMIT = 200000;
	localparam int LONG_HOLD = 600;

	// one row of the directed stimulus; lbl[k] is the typed label of vertex k
	typedef struct packed {
		logic [gao_pkg::VIDX_W-1:0] idx;
		logic [gao_pkg::ROW_W-1:0] bits;
		logic last;
		logic typed;
		logic [NV-1:0][gao_pkg::LABEL_W-1:0] lbl;
	} dir_row_t;

	localparam int DIR_LEN = 17;
	// empty graph, then complete graph with loops, then vertex 0 loses its self-loop
	localparam dir_row_t DIR_TAB [DIR_LEN] = '{
		'{3'd0, 8'h00, 1'b0, 1'b0, 32'h0},
		'{3'd1, 8'h00, 1'b0, 1'b0, 32'h0},
		'{3'd2, 8'h00, 1'b0, 1'b0, 32'h0},
		'{3'd3, 8'h00, 1'b0, 1'b0, 32'h0},
		'{3'd4, 8'h00, 1'b0, 1'b0, 32'h0},
		'{3'd5, 8'h00, 1'b0, 1'b0, 32'h0},
		'{3'd6, 8'h00, 1'b0, 1'b0, 32'h0},
		'{3'd7, 8'h00, 1'b1, 1'b1, 32'h11111111},
		'{3'd0, 8'hFF, 1'b0, 1'b0, 32'h0},
		'{3'd1, 8'hFF, 1'b0, 1'b0, 32'h0},
		'{3'd2, 8'hFF, 1'b0, 1'b0, 32'h0},
		'{3'd3, 8'hFF, 1'b0, 1'b0, 32'h0},
		'{3'd4, 8'hFF, 1'b0, 1'b0, 32'h0},
		'{3'd5, 8'hFF, 1'b0, 1'b0, 32'h0},
		'{3'd6, 8'hFF, 1'b0, 1'b0, 32'h0},
		'{3'd7, 8'hFF, 1'b1, 1'b1, 32'h11111111},
		'{3'd0, 8'hFE, 1'b1, 1'b1, 32'h22222221}
	};

	// vertex counts written between phases, extremes included
	localparam int NUM_PHASES = 11;
	localparam logic [gao_pkg::CNT_W-1:0] COUNT_PLAN [NUM_PHASES] = '{
		4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd15, 4'd8, 4'd4
	};

	logic clk;
	logic arst_n;

	gao_in_if in_ch();
	gao_out_if out_ch();
	gao_cfg_if cfg();

	graph_automorphism_orbits_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg(cfg)
	);

	// predictor copy of the block's stored rows and count
	logic [gao_pkg::ROW_W-1:0] graph_rows [NV];
	logic [gao_pkg::CNT_W-1:0] vertex_cnt;
	int vmap [NV];
	logic [NV-1:0] image_set [NV];
	gao_pkg::out_item_t label_queue [$];

	int fails;
	bit calm;
	bit stall_req;
	int idle_cycles;

	// clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic int eff_count();
		if (vertex_cnt == 0) return 1;
		if (vertex_cnt > NV) return NV;
		return int'(vertex_cnt);
	endfunction

	// extend a partial vertex map to depth d, keeping every checked edge
	function automatic void extend_map(int d, int n, logic [NV-1:0] taken);
		bit ok;
		if (d == n) begin
			for (int i = 0; i < n; i++)
				image_set[i][vmap[i]] = 1'b1;
			return;
		end
		for (int v = 0; v < n; v++) begin
			if (!taken[v]) begin
				vmap[d] = v;
				ok = 1;
				for (int j = 0; j <= d; j++) begin
					if (graph_rows[d][j] != graph_rows[v][vmap[j]]) ok = 0;
					if (graph_rows[j][d] != graph_rows[vmap[j]][v]) ok = 0;
				end
				if (ok) extend_map(d + 1, n, taken | (8'd1 << v));
			end
		end
	endfunction

	// orbit labels for the stored graph, queued in vertex order
	function automatic void predict_orbits();
		int n;
		gao_pkg::out_item_t r;
		n = eff_count();
		for (int i = 0; i < NV; i++) image_set[i] = '0;
		extend_map(0, n, '0);
		for (int k = 0; k < n; k++) begin
			r.vertex = k[gao_pkg::VIDX_W-1:0];
			r.orbit_label = gao_pkg::LABEL_W'(k + 1);
			for (int i = n - 1; i >= 0; i--)
				if (image_set[i][k]) r.orbit_label = gao_pkg::LABEL_W'(i + 1);
			r.last = (k == n - 1);
			label_queue.push_back(r);
		end
	endfunction

	// offer one row request, wait for its acceptance, then update the predictor
	task automatic send_row(input logic [gao_pkg::VIDX_W-1:0] idx,
			input logic [gao_pkg::ROW_W-1:0] bits, input logic last, input logic typed,
			input logic [NV-1:0][gao_pkg::LABEL_W-1:0] lbl);
		int gap;
		gao_pkg::out_item_t r;
		@(negedge clk);
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 17);
			in_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.data.row_index = idx;
		in_ch.data.row_bits = bits;
		in_ch.data.last_row = last;
		do @(posedge clk); while (!in_ch.ready);
		graph_rows[idx] = bits;
		if (last) begin
			if (typed) begin
				for (int k = 0; k < eff_count(); k++) begin
					r.vertex = k[gao_pkg::VIDX_W-1:0];
					r.orbit_label = lbl[k];
					r.last = (k == eff_count() - 1);
					label_queue.push_back(r);
				end
			end else begin
				predict_orbits();
			end
		end
	endtask

	task automatic stop_rows();
		@(negedge clk);
		in_ch.valid = 1'b0;
	endtask

	// wait for all expected results, then keep waiting for any row still in flight
	task automatic drain();
		while (label_queue.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_count(input logic [gao_pkg::CNT_W-1:0] value);
		@(negedge clk);
		cfg.valid = 1'b1;
		cfg.data = value;
		do @(posedge clk); while (!cfg.ready);
		vertex_cnt = value;
		@(negedge clk);
		cfg.valid = 1'b0;
	endtask

	// one random graph: random, undirected or cycle shape, with noise rows
	// and now and then a run started early
	task automatic send_graph();
		int n;
		int mode;
		int dens;
		int stop;
		logic b;
		logic [gao_pkg::ROW_W-1:0] m [NV];
		n = eff_count();
		mode = $urandom_range(0, 2);
		dens = $urandom_range(0, 100);
		for (int i = 0; i < NV; i++) m[i] = gao_pkg::ROW_W'($urandom);
		for (int i = 0; i < n; i++) begin
			for (int j = i; j < n; j++) begin
				if (mode == 1) begin
					b = ($urandom_range(0, 99) < dens);
					m[i][j] = b;
					m[j][i] = b;
				end else if (mode == 2) begin
					b = (j == (i + 1) % n) || (i == (j + 1) % n);
					m[i][j] = b;
					m[j][i] = b;
				end
			end
		end
		stop = ($urandom_range(0, 7) == 0) ? $urandom_range(0, n - 1) : n - 1;
		for (int i = 0; i <= stop; i++) begin
			if (n < NV && $urandom_range(0, 4) == 0)
				send_row(gao_pkg::VIDX_W'($urandom_range(n, NV - 1)),
					gao_pkg::ROW_W'($urandom), 1'b0, 1'b0, '0);
			send_row(gao_pkg::VIDX_W'(i), m[i], i == stop, 1'b0, '0);
		end
	endtask

	// result side: random holds, plus one long hold on request
	initial begin
		int rx_gap;
		rx_gap = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_req) begin
				stall_req = 0;
				rx_gap = LONG_HOLD;
			end else if (rx_gap == 0 && !calm && $urandom_range(0, 7) == 0) begin
				rx_gap = $urandom_range(1, 17);
			end
			if (rx_gap > 0) begin
				out_ch.ready = 1'b0;
				rx_gap--;
			end else begin
				out_ch.ready = 1'b1;
			end
		end
	end

	// compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		gao_pkg::out_item_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (label_queue.size() == 0) begin
				$display("%0t: unexpected result vertex=%0d label=%0d last=%0d", $time,
					out_ch.data.vertex, out_ch.data.orbit_label, out_ch.data.last);
				fails++;
			end else begin
				want = label_queue.pop_front();
				if (out_ch.data.vertex !== want.vertex) begin
					$display("%0t: vertex expected %0d actual %0d", $time,
						want.vertex, out_ch.data.vertex);
					fails++;
				end
				if (out_ch.data.orbit_label !== want.orbit_label) begin
					$display("%0t: orbit_label of vertex %0d expected %0d actual %0d", $time,
						want.vertex, want.orbit_label, out_ch.data.orbit_label);
					fails++;
				end
				if (out_ch.data.last !== want.last) begin
					$display("%0t: last of vertex %0d expected %0d actual %0d", $time,
						want.vertex, want.last, out_ch.data.last);
					fails++;
				end
			end
		end
	end

	// watchdog on cycles with no request accepted anywhere
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
				|| (cfg.valid && cfg.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired", $time);
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		int graphs;
		fails = 0;
		calm = 0;
		stall_req = 0;
		idle_cycles = 0;
		vertex_cnt = 4'd8;
		for (int i = 0; i < NV; i++) graph_rows[i] = '0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part at the reset count; writes every row twice and row 0 a third time
		for (int t = 0; t < DIR_LEN; t++)
			send_row(DIR_TAB[t].idx, DIR_TAB[t].bits, DIR_TAB[t].last,
				DIR_TAB[t].typed, DIR_TAB[t].lbl);
		stop_rows();
		drain();

		// random phases, one vertex count each
		for (int p = 0; p < NUM_PHASES; p++) begin
			write_count(COUNT_PLAN[p]);
			if (p == NUM_PHASES - 1) calm = 1;
			// long result hold while rows keep coming
			if (COUNT_PLAN[p] == 4'd3) stall_req = 1;
			graphs = (eff_count() == NV) ? 1 : (eff_count() == 7) ? 2 : 3;
			for (int g = 0; g < graphs; g++) send_graph();
			stop_rows();
			drain();
		end

		repeat (50) @(posedge clk);
		if (fails == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule
